### rtl/core/grmc_pkg.sv
package grmc_pkg;

    localparam int LAT_W  = 27;
    localparam int LON_W  = 30;
    localparam int ZONE_W = 5;
    localparam int YEAR_W = 12;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_E      = 8'h45;

    localparam logic [3:0] FIELD_TIME   = 4'd1;
    localparam logic [3:0] FIELD_STATUS = 4'd2;
    localparam logic [3:0] FIELD_LAT    = 4'd3;
    localparam logic [3:0] FIELD_NS     = 4'd4;
    localparam logic [3:0] FIELD_LON    = 4'd5;
    localparam logic [3:0] FIELD_EW     = 4'd6;
    localparam logic [3:0] FIELD_DATE   = 4'd9;
    localparam logic [3:0] FIELDS_MIN   = 4'd10;
    localparam logic [3:0] COUNT_MAX    = 4'd15;
    localparam logic [2:0] DIGITS_HHMMSS = 3'd6;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd8;
    localparam logic [ZONE_W-1:0] ZONE_MAX   = 5'd23;
    localparam logic [YEAR_W-1:0] YEAR_BASE  = 12'd2000;
    localparam logic [5:0] HOURS_PER_DAY     = 6'd24;
    localparam logic [3:0] MONTHS_PER_YEAR   = 4'd12;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FEW_FIELDS = 2'd1,
        STATUS_SHORT      = 2'd2,
        STATUS_BAD_VALUE  = 2'd3
    } status_t;

    typedef struct packed {
        logic             few_fields;
        logic             short_field;
        logic             bad_digit;
        logic             fix;
        logic             north;
        logic             east;
        logic [5:0][3:0]  time_digits;
        logic [5:0][3:0]  date_digits;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } line_t;

    typedef struct packed {
        status_t          status;
        logic             fix;
        logic [YEAR_W-1:0] year;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
        logic [LAT_W-1:0] lat;
        logic             north;
        logic [LON_W-1:0] lon;
        logic             east;
    } result_t;

    // 10^digits - 1, clamped to an all-ones word of the given width
    function automatic longint unsigned sat_limit(input int digits, input int width);
        longint unsigned v;
        longint unsigned m;
        v = 1;
        for (int i = 0; i < digits && i < 12; i++) begin
            v = v * 10;
        end
        v = v - 1;
        m = (64'd1 << width) - 64'd1;
        return (v > m) ? m : v;
    endfunction

endpackage

### rtl/core/gps_rmc_time_position_parser.sv
// Channel   Direction  Handshake                   Payload
// rx        in         rx_valid / rx_stall         ch
// result    out        result_valid / result_stall status_code .. is_east
// cfg       in         cfg_valid / cfg_ready       zone_offset_hours
//
// One character per cycle while rx_stall is low. Input register, then the
// line parser; a CR or LF closes the line into a snapshot register, the
// date/time rollover sits between that and the result register, so an
// end-of-line item is registered in the input, snapshot and result registers
// in turn. rx_stall rises only when an end-of-line item finds both the
// snapshot and the result registers held. Reset: zone offset 8, no line.
module gps_rmc_time_position_parser #(
    parameter int LAT_MAX_DIGITS = 8,
    parameter int LON_MAX_DIGITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  ch,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  zone_offset_hours,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status_code,
    output logic        fix_valid,
    output logic [11:0] local_year,
    output logic [3:0]  local_month,
    output logic [4:0]  local_day,
    output logic [4:0]  local_hour,
    output logic [5:0]  local_minute,
    output logic [5:0]  local_second,
    output logic [26:0] latitude_digits,
    output logic        is_north,
    output logic [29:0] longitude_digits,
    output logic        is_east
);

    logic [grmc_pkg::ZONE_W-1:0] zone_reg;
    logic                        line_valid;
    logic                        line_take;
    grmc_pkg::line_t             line;
    grmc_pkg::result_t           result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= grmc_pkg::ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            zone_reg <= zone_offset_hours;
        end
    end

    grmc_scan #(
        .LAT_MAX_DIGITS (LAT_MAX_DIGITS),
        .LON_MAX_DIGITS (LON_MAX_DIGITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .ch         (ch),
        .line_valid (line_valid),
        .line       (line),
        .line_take  (line_take)
    );

    grmc_clock u_clock (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_valid   (line_valid),
        .line         (line),
        .line_take    (line_take),
        .zone         (zone_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign status_code      = result.status;
    assign fix_valid        = result.fix;
    assign local_year       = result.year;
    assign local_month      = result.month;
    assign local_day        = result.day;
    assign local_hour       = result.hour;
    assign local_minute     = result.minute;
    assign local_second     = result.second;
    assign latitude_digits  = result.lat;
    assign is_north         = result.north;
    assign longitude_digits = result.lon;
    assign is_east          = result.east;

    a_fail_zeroes_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status_code != grmc_pkg::STATUS_OK) |->
            local_year == 12'd0 && local_month == 4'd0 && local_day == 5'd0 &&
            local_hour == 5'd0 && local_minute == 6'd0 && local_second == 6'd0)
        else $error("nonzero status with date/time fields set");

    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status_code == grmc_pkg::STATUS_OK) |->
            local_month >= 4'd1 && local_month <= 4'd12 && local_day >= 5'd1 &&
            local_hour <= 5'd23 && local_year >= 12'd2000 && local_year <= 12'd2100)
        else $error("ok result with local date/time out of range");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> line_valid && result_valid && result_stall)
        else $error("input stalled without a held result");

endmodule

### rtl/core/grmc_scan.sv
module grmc_scan #(
    parameter int LAT_MAX_DIGITS = 8,
    parameter int LON_MAX_DIGITS = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  logic [7:0]          ch,
    output logic                line_valid,
    output grmc_pkg::line_t     line,
    input  logic                line_take
);

    localparam int LAT_W = grmc_pkg::LAT_W;
    localparam int LON_W = grmc_pkg::LON_W;
    localparam logic [LAT_W-1:0] LatLimit =
        LAT_W'(grmc_pkg::sat_limit(LAT_MAX_DIGITS, LAT_W));
    localparam logic [LON_W-1:0] LonLimit =
        LON_W'(grmc_pkg::sat_limit(LON_MAX_DIGITS, LON_W));

    logic            ch_valid_reg, ch_valid_next;
    logic [7:0]      ch_reg;
    logic            in_line_reg, in_line_next;
    logic [3:0]      field_reg, field_next;
    logic [3:0]      pos_reg, pos_next;
    logic [5:0][3:0] tdig_reg, tdig_next;
    logic [5:0][3:0] ddig_reg, ddig_next;
    logic [2:0]      tcount_reg, tcount_next;
    logic [2:0]      dcount_reg, dcount_next;
    logic [LAT_W-1:0] lat_reg, lat_next;
    logic [LON_W-1:0] lon_reg, lon_next;
    logic            fix_reg, fix_next;
    logic            north_reg, north_next;
    logic            east_reg, east_next;
    logic            bad_reg, bad_next;
    logic            line_valid_reg, line_valid_next;
    grmc_pkg::line_t line_reg;

    logic            is_digit;
    logic            is_eol;
    logic            emit;
    logic            proc;
    logic [3:0]      dval;
    logic [LAT_W+3:0] lat_sum;
    logic [LON_W+3:0] lon_sum;

    always_comb
    begin
        is_digit = (ch_reg >= grmc_pkg::CH_ZERO) && (ch_reg <= grmc_pkg::CH_NINE);
        is_eol   = (ch_reg == grmc_pkg::CH_CR) || (ch_reg == grmc_pkg::CH_LF);
        dval     = is_digit ? ch_reg[3:0] : 4'd0;
        emit     = ch_valid_reg && in_line_reg && is_eol;
        proc     = ch_valid_reg && (!emit || !line_valid_reg || line_take);
        lat_sum  = ({4'd0, lat_reg} << 3) + ({4'd0, lat_reg} << 1) + (LAT_W+4)'(dval);
        lon_sum  = ({4'd0, lon_reg} << 3) + ({4'd0, lon_reg} << 1) + (LON_W+4)'(dval);
    end

    assign rx_stall = ch_valid_reg && !proc;

    always_comb
    begin
        ch_valid_next = ch_valid_reg;
        if (rx_valid && !rx_stall)
        begin
            ch_valid_next = 1'b1;
        end
        else if (proc)
        begin
            ch_valid_next = 1'b0;
        end

        line_valid_next = line_valid_reg;
        if (proc && emit)
        begin
            line_valid_next = 1'b1;
        end
        else if (line_take)
        begin
            line_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        in_line_next = in_line_reg;
        field_next   = field_reg;
        pos_next     = pos_reg;
        tdig_next    = tdig_reg;
        ddig_next    = ddig_reg;
        tcount_next  = tcount_reg;
        dcount_next  = dcount_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        fix_next     = fix_reg;
        north_next   = north_reg;
        east_next    = east_reg;
        bad_next     = bad_reg;

        if (proc)
        begin
            if (ch_reg == grmc_pkg::CH_DOLLAR)
            begin
                in_line_next = 1'b1;
                field_next   = '0;
                pos_next     = '0;
                tdig_next    = '0;
                ddig_next    = '0;
                tcount_next  = '0;
                dcount_next  = '0;
                lat_next     = '0;
                lon_next     = '0;
                fix_next     = 1'b0;
                north_next   = 1'b0;
                east_next    = 1'b0;
                bad_next     = 1'b0;
            end
            else if (in_line_reg)
            begin
                if (is_eol)
                begin
                    in_line_next = 1'b0;
                end
                else if (ch_reg == grmc_pkg::CH_COMMA)
                begin
                    if (field_reg != grmc_pkg::COUNT_MAX)
                    begin
                        field_next = field_reg + 4'd1;
                    end
                    pos_next = '0;
                end
                else
                begin
                    case (field_reg)
                        grmc_pkg::FIELD_TIME:
                        begin
                            if (pos_reg < 4'(grmc_pkg::DIGITS_HHMMSS))
                            begin
                                tdig_next[pos_reg[2:0]] = dval;
                                tcount_next = pos_reg[2:0] + 3'd1;
                                if (!is_digit)
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        grmc_pkg::FIELD_STATUS:
                        begin
                            if (pos_reg == 4'd0 && ch_reg == grmc_pkg::CH_A)
                            begin
                                fix_next = 1'b1;
                            end
                        end
                        grmc_pkg::FIELD_LAT:
                        begin
                            if (is_digit)
                            begin
                                lat_next = (lat_sum > {4'd0, LatLimit}) ?
                                           LatLimit : lat_sum[LAT_W-1:0];
                            end
                        end
                        grmc_pkg::FIELD_NS:
                        begin
                            if (pos_reg == 4'd0 && ch_reg == grmc_pkg::CH_N)
                            begin
                                north_next = 1'b1;
                            end
                        end
                        grmc_pkg::FIELD_LON:
                        begin
                            if (is_digit)
                            begin
                                lon_next = (lon_sum > {4'd0, LonLimit}) ?
                                           LonLimit : lon_sum[LON_W-1:0];
                            end
                        end
                        grmc_pkg::FIELD_EW:
                        begin
                            if (pos_reg == 4'd0 && ch_reg == grmc_pkg::CH_E)
                            begin
                                east_next = 1'b1;
                            end
                        end
                        grmc_pkg::FIELD_DATE:
                        begin
                            if (pos_reg < 4'(grmc_pkg::DIGITS_HHMMSS))
                            begin
                                ddig_next[pos_reg[2:0]] = dval;
                                dcount_next = pos_reg[2:0] + 3'd1;
                                if (!is_digit)
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (pos_reg != grmc_pkg::COUNT_MAX)
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg   <= 1'b0;
            line_valid_reg <= 1'b0;
            in_line_reg    <= 1'b0;
            field_reg      <= '0;
            pos_reg        <= '0;
            tdig_reg       <= '0;
            ddig_reg       <= '0;
            tcount_reg     <= '0;
            dcount_reg     <= '0;
            lat_reg        <= '0;
            lon_reg        <= '0;
            fix_reg        <= 1'b0;
            north_reg      <= 1'b0;
            east_reg       <= 1'b0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            ch_valid_reg   <= ch_valid_next;
            line_valid_reg <= line_valid_next;
            in_line_reg    <= in_line_next;
            field_reg      <= field_next;
            pos_reg        <= pos_next;
            tdig_reg       <= tdig_next;
            ddig_reg       <= ddig_next;
            tcount_reg     <= tcount_next;
            dcount_reg     <= dcount_next;
            lat_reg        <= lat_next;
            lon_reg        <= lon_next;
            fix_reg        <= fix_next;
            north_reg      <= north_next;
            east_reg       <= east_next;
            bad_reg        <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            ch_reg <= ch;
        end
        if (proc && emit)
        begin
            line_reg.few_fields  <= field_reg < grmc_pkg::FIELDS_MIN;
            line_reg.short_field <= (tcount_reg < grmc_pkg::DIGITS_HHMMSS) ||
                                    (dcount_reg < grmc_pkg::DIGITS_HHMMSS);
            line_reg.bad_digit   <= bad_reg;
            line_reg.fix         <= fix_reg;
            line_reg.north       <= north_reg;
            line_reg.east        <= east_reg;
            line_reg.time_digits <= tdig_reg;
            line_reg.date_digits <= ddig_reg;
            line_reg.lat         <= lat_reg;
            line_reg.lon         <= lon_reg;
        end
    end

    assign line_valid = line_valid_reg;
    assign line       = line_reg;

endmodule

### rtl/core/grmc_clock.sv
module grmc_clock (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               line_valid,
    input  grmc_pkg::line_t                    line,
    output logic                               line_take,
    input  logic [grmc_pkg::ZONE_W-1:0]        zone,
    output logic                               result_valid,
    input  logic                               result_stall,
    output grmc_pkg::result_t                  result
);

    function automatic logic [6:0] two_dig(input logic [3:0] hi, input logic [3:0] lo);
        return ({3'd0, hi} << 3) + ({3'd0, hi} << 1) + {3'd0, lo};
    endfunction

    // leap rule reduces to yy mod 4 for years 2000..2099
    function automatic logic [4:0] last_day(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    logic              result_valid_reg, result_valid_next;
    grmc_pkg::result_t result_reg;
    grmc_pkg::result_t calc;

    logic [6:0] hr, mi, se, dy, mo, yy;
    logic       leap;
    logic [4:0] mlast;
    logic       range_bad;
    logic [4:0] off;
    logic [5:0] hsum;
    logic [5:0] day_inc;
    logic [3:0] mon_inc;

    assign line_take = line_valid && (!result_valid_reg || !result_stall);

    always_comb
    begin
        hr    = two_dig(line.time_digits[0], line.time_digits[1]);
        mi    = two_dig(line.time_digits[2], line.time_digits[3]);
        se    = two_dig(line.time_digits[4], line.time_digits[5]);
        dy    = two_dig(line.date_digits[0], line.date_digits[1]);
        mo    = two_dig(line.date_digits[2], line.date_digits[3]);
        yy    = two_dig(line.date_digits[4], line.date_digits[5]);
        leap  = (yy[1:0] == 2'd0);
        mlast = last_day(mo[3:0], leap);
        off   = (zone > grmc_pkg::ZONE_MAX) ? grmc_pkg::ZONE_MAX : zone;

        range_bad = line.bad_digit || (hr > 7'd23) || (mi > 7'd59) || (se > 7'd60) ||
                    (mo == 7'd0) || (mo > 7'(grmc_pkg::MONTHS_PER_YEAR)) ||
                    (dy == 7'd0) || (dy > {2'd0, mlast});

        calc.fix   = line.fix;
        calc.north = line.north;
        calc.east  = line.east;
        calc.lat   = line.lat;
        calc.lon   = line.lon;

        if (line.few_fields)
        begin
            calc.status = grmc_pkg::STATUS_FEW_FIELDS;
        end
        else if (line.short_field)
        begin
            calc.status = grmc_pkg::STATUS_SHORT;
        end
        else if (range_bad)
        begin
            calc.status = grmc_pkg::STATUS_BAD_VALUE;
        end
        else
        begin
            calc.status = grmc_pkg::STATUS_OK;
        end

        hsum    = {1'b0, hr[4:0]} + {1'b0, off};
        day_inc = {1'b0, dy[4:0]} + 6'd1;
        mon_inc = mo[3:0] + 4'd1;

        calc.year   = grmc_pkg::YEAR_BASE + {5'd0, yy};
        calc.month  = mo[3:0];
        calc.day    = dy[4:0];
        calc.hour   = hsum[4:0];
        calc.minute = mi[5:0];
        calc.second = se[5:0];

        if (hsum >= grmc_pkg::HOURS_PER_DAY)
        begin
            calc.hour = 5'(hsum - grmc_pkg::HOURS_PER_DAY);
            calc.day  = day_inc[4:0];
            if (day_inc > {1'b0, mlast})
            begin
                calc.day   = 5'd1;
                calc.month = mon_inc;
                if (mon_inc > grmc_pkg::MONTHS_PER_YEAR)
                begin
                    calc.month = 4'd1;
                    calc.year  = grmc_pkg::YEAR_BASE + {5'd0, yy} + 12'd1;
                end
            end
        end

        if (calc.status != grmc_pkg::STATUS_OK)
        begin
            calc.year   = '0;
            calc.month  = '0;
            calc.day    = '0;
            calc.hour   = '0;
            calc.minute = '0;
            calc.second = '0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (line_take)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_take)
        begin
            result_reg <= calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### tb/sv/tb_gps_rmc_time_position_parser.sv
module tb_gps_rmc_time_position_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_DIGITS   = 8;
    localparam int LON_DIGITS   = 9;
    localparam int IDLE_LIMIT   = 600;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CHARS = 1200;
    localparam int PHASE_CHARS  = 300;

    typedef logic [7:0] char_t;

    class rmc_scoreboard;
        logic [grmc_pkg::ZONE_W-1:0] zone;
        bit                open;
        logic [3:0]        field_idx;
        logic [3:0]        char_idx;
        logic [3:0]        time_bcd [6];
        logic [3:0]        date_bcd [6];
        int unsigned       time_len;
        int unsigned       date_len;
        longint unsigned   lat_acc;
        longint unsigned   lon_acc;
        longint unsigned   lat_cap;
        longint unsigned   lon_cap;
        bit                fix_seen;
        bit                north_seen;
        bit                east_seen;
        bit                bad_seen;
        grmc_pkg::result_t pending_results [$];
        int unsigned       fails;
        int unsigned       reported;

        function new();
            zone     = grmc_pkg::ZONE_RESET;
            open     = 0;
            fails    = 0;
            reported = 0;
            lat_cap  = digit_cap(LAT_DIGITS, grmc_pkg::LAT_W);
            lon_cap  = digit_cap(LON_DIGITS, grmc_pkg::LON_W);
            clear_capture();
        endfunction

        function longint unsigned digit_cap(int n, int w);
            longint unsigned v;
            longint unsigned m;
            v = 1;
            repeat (n) v = v * 10;
            v = v - 1;
            m = (64'd1 << w) - 64'd1;
            return (v > m) ? m : v;
        endfunction

        function longint unsigned grow(longint unsigned acc, int unsigned d,
                                       longint unsigned cap);
            longint unsigned n;
            n = acc * 10 + d;
            return (n > cap) ? cap : n;
        endfunction

        function int unsigned month_days(int unsigned m, int unsigned y);
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            if (m == 2)
                return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
            return 31;
        endfunction

        function void clear_capture();
            field_idx  = 0;
            char_idx   = 0;
            time_len   = 0;
            date_len   = 0;
            lat_acc    = 0;
            lon_acc    = 0;
            fix_seen   = 0;
            north_seen = 0;
            east_seen  = 0;
            bad_seen   = 0;
            foreach (time_bcd[i])
            begin
                time_bcd[i] = 0;
                date_bcd[i] = 0;
            end
        endfunction

        function void close_line();
            grmc_pkg::result_t r;
            grmc_pkg::status_t st;
            int unsigned off;
            int unsigned yr;
            int unsigned mo;
            int unsigned dy;
            int unsigned hr;
            int unsigned mi;
            int unsigned se;
            off = (zone > grmc_pkg::ZONE_MAX) ? grmc_pkg::ZONE_MAX : zone;
            st  = grmc_pkg::STATUS_OK;
            yr  = 0;
            mo  = 0;
            dy  = 0;
            hr  = 0;
            mi  = 0;
            se  = 0;
            if (field_idx < grmc_pkg::FIELDS_MIN)
                st = grmc_pkg::STATUS_FEW_FIELDS;
            else if (time_len < 6 || date_len < 6)
                st = grmc_pkg::STATUS_SHORT;
            else
            begin
                hr = time_bcd[0] * 10 + time_bcd[1];
                mi = time_bcd[2] * 10 + time_bcd[3];
                se = time_bcd[4] * 10 + time_bcd[5];
                dy = date_bcd[0] * 10 + date_bcd[1];
                mo = date_bcd[2] * 10 + date_bcd[3];
                yr = date_bcd[4] * 10 + date_bcd[5] + 2000;
                if (bad_seen || hr > 23 || mi > 59 || se > 60 || mo < 1 || mo > 12 ||
                    dy < 1 || dy > month_days(mo, yr))
                    st = grmc_pkg::STATUS_BAD_VALUE;
            end
            if (st != grmc_pkg::STATUS_OK)
            begin
                yr = 0;
                mo = 0;
                dy = 0;
                hr = 0;
                mi = 0;
                se = 0;
            end
            else
            begin
                hr = hr + off;
                if (hr >= 24)
                begin
                    hr = hr - 24;
                    dy = dy + 1;
                    if (dy > month_days(mo, yr))
                    begin
                        dy = 1;
                        mo = mo + 1;
                        if (mo > 12)
                        begin
                            mo = 1;
                            yr = yr + 1;
                        end
                    end
                end
            end
            r.status = st;
            r.fix    = fix_seen;
            r.year   = yr[grmc_pkg::YEAR_W-1:0];
            r.month  = mo[3:0];
            r.day    = dy[4:0];
            r.hour   = hr[4:0];
            r.minute = mi[5:0];
            r.second = se[5:0];
            r.lat    = lat_acc[grmc_pkg::LAT_W-1:0];
            r.north  = north_seen;
            r.lon    = lon_acc[grmc_pkg::LON_W-1:0];
            r.east   = east_seen;
            pending_results.push_back(r);
        endfunction

        function void note_char(char_t c);
            bit digit;
            digit = (c >= grmc_pkg::CH_ZERO) && (c <= grmc_pkg::CH_NINE);
            if (c == grmc_pkg::CH_DOLLAR)
            begin
                open = 1;
                clear_capture();
                return;
            end
            if (!open)
                return;
            if (c == grmc_pkg::CH_CR || c == grmc_pkg::CH_LF)
            begin
                close_line();
                open = 0;
                return;
            end
            if (c == grmc_pkg::CH_COMMA)
            begin
                if (field_idx < grmc_pkg::COUNT_MAX)
                    field_idx++;
                char_idx = 0;
                return;
            end
            case (field_idx)
                grmc_pkg::FIELD_TIME:
                    if (char_idx < 6)
                    begin
                        time_bcd[char_idx] = digit ? 4'(c - grmc_pkg::CH_ZERO) : 4'd0;
                        if (!digit)
                            bad_seen = 1;
                        time_len = char_idx + 1;
                    end
                grmc_pkg::FIELD_STATUS:
                    if (char_idx == 0 && c == grmc_pkg::CH_A)
                        fix_seen = 1;
                grmc_pkg::FIELD_LAT:
                    if (digit)
                        lat_acc = grow(lat_acc, c - grmc_pkg::CH_ZERO, lat_cap);
                grmc_pkg::FIELD_NS:
                    if (char_idx == 0 && c == grmc_pkg::CH_N)
                        north_seen = 1;
                grmc_pkg::FIELD_LON:
                    if (digit)
                        lon_acc = grow(lon_acc, c - grmc_pkg::CH_ZERO, lon_cap);
                grmc_pkg::FIELD_EW:
                    if (char_idx == 0 && c == grmc_pkg::CH_E)
                        east_seen = 1;
                grmc_pkg::FIELD_DATE:
                    if (char_idx < 6)
                    begin
                        date_bcd[char_idx] = digit ? 4'(c - grmc_pkg::CH_ZERO) : 4'd0;
                        if (!digit)
                            bad_seen = 1;
                        date_len = char_idx + 1;
                    end
                default: ;
            endcase
            if (char_idx < grmc_pkg::COUNT_MAX)
                char_idx++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] have);
            if (want !== have)
            begin
                fails++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch %s: expected %0d, got %0d", name, want, have);
                end
            end
        endfunction

        function void check_result(grmc_pkg::result_t got);
            grmc_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                fails++;
                if (reported < 10)
                begin
                    reported++;
                    $display("result with no line pending: status %0d", got.status);
                end
                return;
            end
            want = pending_results.pop_front();
            compare_field("status_code", want.status, got.status);
            compare_field("fix_valid", want.fix, got.fix);
            compare_field("local_year", want.year, got.year);
            compare_field("local_month", want.month, got.month);
            compare_field("local_day", want.day, got.day);
            compare_field("local_hour", want.hour, got.hour);
            compare_field("local_minute", want.minute, got.minute);
            compare_field("local_second", want.second, got.second);
            compare_field("latitude_digits", want.lat, got.lat);
            compare_field("is_north", want.north, got.north);
            compare_field("longitude_digits", want.lon, got.lon);
            compare_field("is_east", want.east, got.east);
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              rx_valid = 0;
    logic              rx_stall;
    char_t             ch = '0;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [grmc_pkg::ZONE_W-1:0] zone_offset_hours = '0;
    logic              result_valid;
    logic              result_stall = 0;
    logic [1:0]        status_code;
    logic              fix_valid;
    logic [11:0]       local_year;
    logic [3:0]        local_month;
    logic [4:0]        local_day;
    logic [4:0]        local_hour;
    logic [5:0]        local_minute;
    logic [5:0]        local_second;
    logic [26:0]       latitude_digits;
    logic              is_north;
    logic [29:0]       longitude_digits;
    logic              is_east;

    rmc_scoreboard     sb = new();
    grmc_pkg::result_t seen;
    char_t             stream [$];
    int                burst_left = 0;
    int                idle_cycles = 0;

    gps_rmc_time_position_parser #(
        .LAT_MAX_DIGITS(LAT_DIGITS),
        .LON_MAX_DIGITS(LON_DIGITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .ch(ch),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .zone_offset_hours(zone_offset_hours),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status_code(status_code),
        .fix_valid(fix_valid),
        .local_year(local_year),
        .local_month(local_month),
        .local_day(local_day),
        .local_hour(local_hour),
        .local_minute(local_minute),
        .local_second(local_second),
        .latitude_digits(latitude_digits),
        .is_north(is_north),
        .longitude_digits(longitude_digits),
        .is_east(is_east)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: runs of no stall, random stall and solid stall
    initial
    begin
        int mode;
        int run;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = (mode == 3) ? $urandom_range(1, 20) : $urandom_range(1, 40);
            repeat (run)
            begin
                @(negedge clk);
                case (mode)
                    0:       result_stall <= 1'b0;
                    3:       result_stall <= 1'b1;
                    default: result_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen.status = grmc_pkg::status_t'(status_code);
            seen.fix    = fix_valid;
            seen.year   = local_year;
            seen.month  = local_month;
            seen.day    = local_day;
            seen.hour   = local_hour;
            seen.minute = local_minute;
            seen.second = local_second;
            seen.lat    = latitude_digits;
            seen.north  = is_north;
            seen.lon    = longitude_digits;
            seen.east   = is_east;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_gps_rmc_time_position_parser NOT OK");
                $finish;
            end
        end
    end

    task automatic send_char(input char_t c);
        @(negedge clk);
        rx_valid <= 1'b1;
        ch       <= c;
        do
            @(posedge clk);
        while (rx_stall);
        sb.note_char(c);
    endtask

    task automatic rx_gap(input int n);
        @(negedge clk);
        rx_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic flush_stream();
        foreach (stream[i])
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    rx_gap($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_char(stream[i]);
        end
        stream.delete();
    endtask

    // hold the sender until every line has been reported
    task automatic settle();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_zone(input logic [grmc_pkg::ZONE_W-1:0] v);
        @(negedge clk);
        cfg_valid         <= 1'b1;
        zone_offset_hours <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.zone = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic put_char(input char_t c);
        stream.push_back(c);
    endtask

    task automatic put_text(input string s);
        foreach (s[i])
            stream.push_back(s[i]);
    endtask

    task automatic put_two(input int unsigned v);
        put_char(char_t'(grmc_pkg::CH_ZERO + v / 10));
        put_char(char_t'(grmc_pkg::CH_ZERO + v % 10));
    endtask

    task automatic put_digits(input int unsigned n, input int unsigned point_at);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i == point_at)
                put_text(".");
            put_char(char_t'(grmc_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    function automatic char_t pick_char();
        case ($urandom_range(0, 6))
            0, 1, 2: return char_t'(grmc_pkg::CH_ZERO + $urandom_range(0, 9));
            3:       return grmc_pkg::CH_COMMA;
            4:       return ".";
            5:       return grmc_pkg::CH_A;
            default: return char_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic end_line();
        case ($urandom_range(0, 7))
            0: ;
            1, 2: put_char(grmc_pkg::CH_CR);
            3, 4: put_char(grmc_pkg::CH_LF);
            default:
            begin
                put_char(grmc_pkg::CH_CR);
                put_char(grmc_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic put_letter(input char_t good, input string other);
        case ($urandom_range(0, 3))
            0, 1:    put_char(good);
            2:       put_text(other);
            default: put_char(pick_char());
        endcase
    endtask

    task automatic gen_line();
        int unsigned kind;
        int unsigned dd;
        int unsigned mo;
        int unsigned yy;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6)) put_char(char_t'($urandom_range(0, 255)));
            return;
        end
        put_char(grmc_pkg::CH_DOLLAR);
        if (kind == 1)
        begin
            repeat ($urandom_range(0, 40)) put_char(pick_char());
            end_line();
            return;
        end
        if ($urandom_range(0, 3) != 0)
            put_text("GPRMC");
        put_char(grmc_pkg::CH_COMMA);
        case ($urandom_range(0, 7))
            0: repeat ($urandom_range(0, 8)) put_char(pick_char());
            1:
            begin
                put_two($urandom_range(0, 99));
                put_two($urandom_range(0, 99));
                put_two($urandom_range(0, 99));
            end
            default:
            begin
                put_two($urandom_range(0, 1) ? $urandom_range(18, 23) : $urandom_range(0, 23));
                put_two($urandom_range(0, 59));
                put_two($urandom_range(0, 60));
                if ($urandom_range(0, 1))
                    put_text(".00");
            end
        endcase
        put_char(grmc_pkg::CH_COMMA);
        put_letter(grmc_pkg::CH_A, "V");
        put_char(grmc_pkg::CH_COMMA);
        put_digits($urandom_range(0, 12), 4);
        put_char(grmc_pkg::CH_COMMA);
        put_letter(grmc_pkg::CH_N, "S");
        put_char(grmc_pkg::CH_COMMA);
        put_digits($urandom_range(0, 13), 5);
        put_char(grmc_pkg::CH_COMMA);
        put_letter(grmc_pkg::CH_E, "W");
        put_char(grmc_pkg::CH_COMMA);
        put_digits($urandom_range(0, 4), 3);
        put_char(grmc_pkg::CH_COMMA);
        if ($urandom_range(0, 15) == 0)
            put_char(char_t'($urandom_range(0, 255)));
        put_digits($urandom_range(0, 4), 3);
        put_char(grmc_pkg::CH_COMMA);
        case ($urandom_range(0, 7))
            0:
            begin
                put_two($urandom_range(0, 39));
                put_two($urandom_range(0, 19));
                put_two($urandom_range(0, 99));
            end
            1: put_digits($urandom_range(0, 5), 9);
            default:
            begin
                yy = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0:       mo = 12;
                    1:       mo = 2;
                    default: mo = $urandom_range(1, 12);
                endcase
                dd = sb.month_days(mo, 2000 + yy);
                if ($urandom_range(0, 1))
                    dd = $urandom_range(1, dd);
                put_two(dd);
                put_two(mo);
                put_two(yy);
            end
        endcase
        if ($urandom_range(0, 7) != 0)
            put_char(grmc_pkg::CH_COMMA);
        repeat ($urandom_range(0, 6))
        begin
            put_char(grmc_pkg::CH_COMMA);
            put_digits($urandom_range(0, 3), 1);
        end
        if ($urandom_range(0, 1))
        begin
            put_text("*");
            put_digits(2, 9);
        end
        end_line();
    endtask

    initial
    begin
        int unsigned chars;
        int unsigned phase;
        int unsigned phase_chars;
        logic [grmc_pkg::ZONE_W-1:0] zone_pick;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_zone(grmc_pkg::ZONE_MAX);

        // ignored outside a line; year-end rollover; CR LF gives one item
        put_text("x");
        put_char(grmc_pkg::CH_CR);
        put_text("$GPRMC,235959,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W*6A");
        put_char(grmc_pkg::CH_CR);
        put_char(grmc_pkg::CH_LF);
        // leap day, saturating position
        put_text("$,120000,V,123456789012,S,9876543210987,W,,,280224,");
        put_char(grmc_pkg::CH_CR);
        // non-leap end of February
        put_text("$,010000,A,0,N,0,E,,,280299,");
        put_char(grmc_pkg::CH_LF);
        put_text("$,1,A");
        put_char(grmc_pkg::CH_CR);
        put_text("$,12345,A,,,,,,,010100,");
        put_char(grmc_pkg::CH_LF);
        put_text("$,12a456,A,,,,,,,010100,");
        put_char(grmc_pkg::CH_CR);
        put_text("$,240000,A,,,,,,,300200,");
        put_char(grmc_pkg::CH_CR);
        put_text("$,235960,A,,,,,,,311200,,,,,,,,,,,");
        put_char(grmc_pkg::CH_CR);
        put_text("$,1234567,A,1.2.3,N,,E,,,0101991,");
        put_char(grmc_pkg::CH_CR);
        // restart inside a line
        put_text("$,000000,A,");
        put_text("$,000061,A,,,,,,,011300,");
        put_char(grmc_pkg::CH_LF);
        put_text("$,");
        put_char(8'h00);
        put_text("00000,A,,,,,");
        put_char(8'hFF);
        put_text(",,010100,");
        put_char(grmc_pkg::CH_CR);
        flush_stream();

        chars = 0;
        phase = 0;
        while (chars < RANDOM_CHARS)
        begin
            settle();
            case (phase)
                0:       zone_pick = '0;
                1:       zone_pick = '1;
                2:       zone_pick = grmc_pkg::ZONE_RESET;
                default: zone_pick = grmc_pkg::ZONE_W'($urandom_range(0, 31));
            endcase
            write_zone(zone_pick);
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS)
            begin
                gen_line();
                phase_chars += stream.size();
                flush_stream();
            end
            chars += phase_chars;
            phase++;
        end

        settle();
        if (sb.fails == 0 && sb.pending_results.size() == 0)
            $display("tb_gps_rmc_time_position_parser OK");
        else
            $display("tb_gps_rmc_time_position_parser NOT OK");
        $finish;
    end

endmodule
